@@ hdl/rgbsp_pkg.sv @@
// Shared constants, basis tables and coefficient rounding for the RGB-to-spectrum core.
package rgbsp_pkg;

    localparam int NUM_BINS    = 10;
    localparam int CHAN_W      = 8;
    localparam int POWER_W     = 21;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 216;

    // Which basis the middle-minus-smallest weight drives
    typedef enum logic [1:0] {
        SEC_CYAN,
        SEC_MAGENTA,
        SEC_YELLOW
    } sec_basis_t;

    // Which basis the largest-minus-middle weight drives
    typedef enum logic [1:0] {
        PRI_RED,
        PRI_GREEN,
        PRI_BLUE
    } pri_basis_t;

    typedef logic [15:0] basis_row_t [NUM_BINS];

    // Basis spectra in units of 1/10000, 397 nm first
    localparam basis_row_t BASIS_WHITE =
        '{16'd10000, 16'd10000, 16'd9999, 16'd9993, 16'd9992,
          16'd9998, 16'd10000, 16'd10000, 16'd10000, 16'd10000};
    localparam basis_row_t BASIS_CYAN =
        '{16'd9710, 16'd9426, 16'd10007, 16'd10007, 16'd10007,
          16'd10007, 16'd1564, 16'd0, 16'd0, 16'd0};
    localparam basis_row_t BASIS_MAGENTA =
        '{16'd10000, 16'd10000, 16'd9685, 16'd2229, 16'd0,
          16'd458, 16'd8369, 16'd10000, 16'd10000, 16'd9959};
    localparam basis_row_t BASIS_YELLOW =
        '{16'd1, 16'd0, 16'd1088, 16'd6651, 16'd10000,
          16'd10000, 16'd9996, 16'd9586, 16'd9685, 16'd9840};
    localparam basis_row_t BASIS_RED =
        '{16'd1012, 16'd515, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd8325, 16'd10149, 16'd10149, 16'd10149};
    localparam basis_row_t BASIS_GREEN =
        '{16'd0, 16'd0, 16'd273, 16'd7937, 16'd10000,
          16'd9418, 16'd1719, 16'd0, 16'd0, 16'd25};
    localparam basis_row_t BASIS_BLUE =
        '{16'd10000, 16'd10000, 16'd8916, 16'd3323, 16'd0,
          16'd0, 16'd3, 16'd369, 16'd483, 16'd496};

    // Round a 1/10000 coefficient to fixed point with frac fraction bits
    function automatic int unsigned to_fixed(input logic [15:0] c, input int unsigned frac);
        logic [63:0] scaled;
        scaled = 64'(c) << frac;
        return 32'((scaled + 64'd5000) / 64'd10000);
    endfunction

endpackage

@@ hdl/rgb_to_spectrum_ten_bin_core.sv @@
// Pipelined Smits RGB-to-spectrum converter, ten bins from 397 nm to 703 nm.
//
// Usage:
//   s_* carries one RGB pixel per transfer (red, green, blue, 8 bits each).
//   m_* carries ten 21-bit spectral samples per transfer, 397 nm in the low bits.
//   Each sample is the spectrum value times 2^COEF_FRAC_BITS times 255.
// Pipeline:
//   Stage 1 sorts the channels and forms the white, secondary and primary weights.
//   Stage 2 multiplies the weights by the selected fixed-point basis coefficients.
//   Stage 3 adds the three products per bin into the output register.
// Flow: an input transfer passes through the stage 1, 2 and 3 registers, and m_tvalid
// rises once it reaches the stage 3 output register. Throughput is one pixel per cycle
// through the three-stage pipeline while the output is not stalled by m_tready.
// Stalls: each stage advances whenever the stage after it is empty or moving, so
// bubbles collapse and s_tready stays high until all three stages hold a pixel
// while m_tready is low. Nothing is dropped or repeated during a stall.
// Reset: rst_n clears all stage valid bits; the core is ready as soon as reset is
// released.
module rgb_to_spectrum_ten_bin_core #(
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fields from bit 0: red[7:0], green[15:8], blue[23:16]
    input  logic [rgbsp_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // fields from bit 0: power_397nm, power_431nm, ... power_703nm, 21 bits each,
    // zero pad in [215:210]
    output logic [rgbsp_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int NB     = rgbsp_pkg::NUM_BINS;
    localparam int CW     = rgbsp_pkg::CHAN_W;
    localparam int PW     = rgbsp_pkg::POWER_W;
    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int PROD_W = CW + COEF_W;
    localparam int SUM_W  = (PROD_W + 2 > PW) ? PROD_W + 2 : PW;

    // Stage advance enables
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // Stage 1: channel ordering and weights
    logic [CW-1:0] red, green, blue;
    logic [CW-1:0] w_white_next, w_sec_next, w_pri_next;
    rgbsp_pkg::sec_basis_t sec_next;
    rgbsp_pkg::pri_basis_t pri_next;
    logic [CW-1:0] w_white_reg, w_sec_reg, w_pri_reg;
    rgbsp_pkg::sec_basis_t sec_reg;
    rgbsp_pkg::pri_basis_t pri_reg;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    always_comb
    begin
        if (red <= green && red <= blue)
        begin
            w_white_next = red;
            sec_next     = rgbsp_pkg::SEC_CYAN;
            if (green <= blue)
            begin
                w_sec_next = green - red;
                w_pri_next = blue - green;
                pri_next   = rgbsp_pkg::PRI_BLUE;
            end
            else
            begin
                w_sec_next = blue - red;
                w_pri_next = green - blue;
                pri_next   = rgbsp_pkg::PRI_GREEN;
            end
        end
        else if (green <= red && green <= blue)
        begin
            w_white_next = green;
            sec_next     = rgbsp_pkg::SEC_MAGENTA;
            if (red <= blue)
            begin
                w_sec_next = red - green;
                w_pri_next = blue - red;
                pri_next   = rgbsp_pkg::PRI_BLUE;
            end
            else
            begin
                w_sec_next = blue - green;
                w_pri_next = red - blue;
                pri_next   = rgbsp_pkg::PRI_RED;
            end
        end
        else
        begin
            w_white_next = blue;
            sec_next     = rgbsp_pkg::SEC_YELLOW;
            if (red <= green)
            begin
                w_sec_next = red - blue;
                w_pri_next = green - red;
                pri_next   = rgbsp_pkg::PRI_GREEN;
            end
            else
            begin
                w_sec_next = green - blue;
                w_pri_next = red - green;
                pri_next   = rgbsp_pkg::PRI_RED;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            w_white_reg <= w_white_next;
            w_sec_reg   <= w_sec_next;
            w_pri_reg   <= w_pri_next;
            sec_reg     <= sec_next;
            pri_reg     <= pri_next;
        end
    end

    // Stages 2 and 3, one lane per spectral bin
    logic [PROD_W-1:0] prod_white_reg [NB];
    logic [PROD_W-1:0] prod_sec_reg   [NB];
    logic [PROD_W-1:0] prod_pri_reg   [NB];
    logic [PW-1:0]     power_reg      [NB];

    for (genvar i = 0; i < NB; i++)
    begin : g_bin
        localparam logic [COEF_W-1:0] C_WHITE = COEF_W'(rgbsp_pkg::to_fixed(
            rgbsp_pkg::BASIS_WHITE[i], COEF_FRAC_BITS));
        localparam logic [COEF_W-1:0] C_CYAN = COEF_W'(rgbsp_pkg::to_fixed(
            rgbsp_pkg::BASIS_CYAN[i], COEF_FRAC_BITS));
        localparam logic [COEF_W-1:0] C_MAGENTA = COEF_W'(rgbsp_pkg::to_fixed(
            rgbsp_pkg::BASIS_MAGENTA[i], COEF_FRAC_BITS));
        localparam logic [COEF_W-1:0] C_YELLOW = COEF_W'(rgbsp_pkg::to_fixed(
            rgbsp_pkg::BASIS_YELLOW[i], COEF_FRAC_BITS));
        localparam logic [COEF_W-1:0] C_RED = COEF_W'(rgbsp_pkg::to_fixed(
            rgbsp_pkg::BASIS_RED[i], COEF_FRAC_BITS));
        localparam logic [COEF_W-1:0] C_GREEN = COEF_W'(rgbsp_pkg::to_fixed(
            rgbsp_pkg::BASIS_GREEN[i], COEF_FRAC_BITS));
        localparam logic [COEF_W-1:0] C_BLUE = COEF_W'(rgbsp_pkg::to_fixed(
            rgbsp_pkg::BASIS_BLUE[i], COEF_FRAC_BITS));

        logic [COEF_W-1:0] sec_coef, pri_coef;
        logic [SUM_W-1:0]  sum;

        // Coefficient select
        always_comb
        begin
            case (sec_reg)
                rgbsp_pkg::SEC_CYAN:    sec_coef = C_CYAN;
                rgbsp_pkg::SEC_MAGENTA: sec_coef = C_MAGENTA;
                rgbsp_pkg::SEC_YELLOW:  sec_coef = C_YELLOW;
                default:                sec_coef = '0;
            endcase
            case (pri_reg)
                rgbsp_pkg::PRI_RED:   pri_coef = C_RED;
                rgbsp_pkg::PRI_GREEN: pri_coef = C_GREEN;
                rgbsp_pkg::PRI_BLUE:  pri_coef = C_BLUE;
                default:              pri_coef = '0;
            endcase
        end

        // Stage 2: products
        always_ff @(posedge clk)
        begin
            if (en2)
            begin
                prod_white_reg[i] <= PROD_W'(w_white_reg) * PROD_W'(C_WHITE);
                prod_sec_reg[i]   <= PROD_W'(w_sec_reg) * PROD_W'(sec_coef);
                prod_pri_reg[i]   <= PROD_W'(w_pri_reg) * PROD_W'(pri_coef);
            end
        end

        // Stage 3: sum of three products, low bits kept
        assign sum = SUM_W'(prod_white_reg[i]) + SUM_W'(prod_sec_reg[i])
                   + SUM_W'(prod_pri_reg[i]);

        always_ff @(posedge clk)
        begin
            if (en3)
                power_reg[i] <= sum[PW-1:0];
        end
    end

    // Output packing
    always_comb
    begin
        m_tdata = '0;
        for (int i = 0; i < NB; i++)
            m_tdata[i*PW +: PW] = power_reg[i];
    end

    // Checks
    logic [CW-1:0] in_max;

    assign in_max = (red >= green && red >= blue) ? red :
                    (green >= blue) ? green : blue;

    // The three weights always add up to the largest channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=>
            ((CW+2)'(w_white_reg) + (CW+2)'(w_sec_reg) + (CW+2)'(w_pri_reg))
                == (CW+2)'($past(in_max)))
        else $error("stage 1 weights do not sum to the largest channel");

    // A pixel in stage 2 moves into an empty output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !v3_reg) |=> v3_reg)
        else $error("stage 2 pixel did not advance into empty output stage");

    // Input is refused only when every stage is full and the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && !m_tready))
        else $error("input stalled while pipeline has room");

    // A stalled output keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !m_tready) |=> (v3_reg && $stable(m_tdata)))
        else $error("stalled result changed or was lost");

endmodule
